// File: sv/lfpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpa_pkg
// Shared constants and types for the LIFO free page allocator.
// ----------------------------------------------------------------------------
package lfpa_pkg;

	localparam int PAGE_W     = 52;
	localparam int CNT_W      = 13;
	localparam int MAX_PAGES  = 4096;
	localparam int ADDR_W     = $clog2(MAX_PAGES);
	localparam int BATCH_SIZE = 510;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = PAGE_W;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} lfpa_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_PAGE  = 1'b0,
		REG_TOTAL_PAGES = 1'b1
	} lfpa_reg_t;

	typedef struct packed {
		logic              from_mem;
		logic [PAGE_W-1:0] page;
		logic              ok;
		logic              overflow;
	} lfpa_res_t;

endpackage

// File: sv/lfpa_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpa_req_if
// Request channel: allocate or free a page.
// ----------------------------------------------------------------------------
interface lfpa_req_if import lfpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic              operation;
	logic [PAGE_W-1:0] page;

	modport source (output valid, output operation, output page, input ready);
	modport sink   (input valid, input operation, input page, output ready);
endinterface

// File: sv/lfpa_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfpa_rsp_if
// Response channel: granted page and status flags.
// ----------------------------------------------------------------------------
interface lfpa_rsp_if import lfpa_pkg::*;;
	logic              valid;
	logic              ready;
	logic [PAGE_W-1:0] granted_page;
	logic              ok;
	logic              overflow;

	modport source (output valid, output granted_page, output ok, output overflow,
		input ready);
	modport sink   (input valid, input granted_page, input ok, input overflow,
		output ready);
endinterface

// File: sv/lifo_free_page_allocator.sv
`timescale 1ns / 1ps
// Stages: stack SRAM read register, output register. Frees push unless the stack is full;
// allocs pop unless it is empty. One request per cycle while the output is not stalled.
// Reset: counters, batch state and handshakes clear at once; stack contents stay undefined
// and need no clearing pass, since only entries below the stack count are read.
// A config write restarts the stack and batch counters the same way; handshakes go on.
// ----------------------------------------------------------------------------
// lifo_free_page_allocator
// Page allocator with an SRAM free stack and batch claiming of unused pages.
// ----------------------------------------------------------------------------
module lifo_free_page_allocator import lfpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	lfpa_req_if.sink             req,
	lfpa_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic [PAGE_W-1:0] mem [MAX_PAGES];

	logic [PAGE_W-1:0] start_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PAGE_W-1:0] bn_q;
	logic [CNT_W-1:0]  bl_q;
	logic [CNT_W-1:0]  used_q;

	logic              valid_s1;
	lfpa_res_t         res_s1;
	logic [PAGE_W-1:0] rd_data_s1;
	logic              valid_s2;
	lfpa_res_t         res_s2;

	logic              acc, is_free, full, empty, refill, push, pop, adv_s1;
	logic [CNT_W-1:0]  room, add, bl_eff, cnt_m1;
	logic [PAGE_W-1:0] bn_eff;
	lfpa_res_t         res_d;

	always_comb begin
		adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
		req.ready = !valid_s1 || adv_s1;
		acc       = req.valid && req.ready;
		is_free   = req.operation == OP_FREE;
		full      = cnt_q == CNT_W'(MAX_PAGES);
		empty     = cnt_q == '0;
		cnt_m1    = cnt_q - CNT_W'(1);
		refill    = (bl_q == '0) && (used_q < total_q);
		room      = total_q - used_q;
		add       = (room > CNT_W'(BATCH_SIZE)) ? CNT_W'(BATCH_SIZE) : room;
		bl_eff    = refill ? add : bl_q;
		bn_eff    = refill ? (start_q + PAGE_W'(used_q) + PAGE_W'(add) - PAGE_W'(1)) : bn_q;
		push      = acc && is_free && !full;
		pop       = acc && !is_free && !empty;

		res_d = '{from_mem: 1'b0, page: '0, ok: 1'b0, overflow: 1'b0};
		if (is_free) begin
			res_d.ok       = !full;
			res_d.overflow = full;
		end else if (!empty) begin
			res_d.from_mem = 1'b1;
			res_d.ok       = 1'b1;
		end else if (bl_eff != '0) begin
			res_d.page = bn_eff;
			res_d.ok   = 1'b1;
		end
	end

	// stack SRAM: one push or one pop per cycle, registered read
	always_ff @(posedge clk) begin
		if (push) begin
			mem[cnt_q[ADDR_W-1:0]] <= req.page;
		end
		if (pop) begin
			rd_data_s1 <= mem[cnt_m1[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			total_q <= '0;
			cnt_q   <= '0;
			bn_q    <= '0;
			bl_q    <= '0;
			used_q  <= CNT_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_START_PAGE: begin
					start_q <= cfg_wdata[PAGE_W-1:0];
					cnt_q   <= '0;
					bn_q    <= '0;
					bl_q    <= '0;
					used_q  <= CNT_W'(1);
				end
				REG_TOTAL_PAGES: begin
					total_q <= cfg_wdata[CNT_W-1:0];
					cnt_q   <= '0;
					bn_q    <= '0;
					bl_q    <= '0;
					used_q  <= CNT_W'(1);
				end
				default: begin
				end
			endcase
		end else if (acc) begin
			if (is_free) begin
				if (!full) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end else if (!empty) begin
				cnt_q <= cnt_m1;
			end else begin
				if (refill) begin
					used_q <= used_q + add;
				end
				if (bl_eff != '0) begin
					bn_q <= bn_eff - PAGE_W'(1);
					bl_q <= bl_eff - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (acc) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			res_s1 <= res_d;
		end
		if (adv_s1) begin
			res_s2 <= '{from_mem: res_s1.from_mem,
				page: res_s1.from_mem ? rd_data_s1 : res_s1.page,
				ok: res_s1.ok,
				overflow: res_s1.overflow};
		end
	end

	assign rsp.valid        = valid_s2;
	assign rsp.granted_page = res_s2.page;
	assign rsp.ok           = res_s2.ok;
	assign rsp.overflow     = res_s2.overflow;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_PAGES))
		else $error("stack count above capacity");

	a_batch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bl_q <= CNT_W'(BATCH_SIZE))
		else $error("batch count above batch size");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !is_free && !empty && !cfg_we) |=> (cnt_q == $past(cnt_m1)))
		else $error("pop did not decrement stack count");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.ok && res_s2.overflow))
		else $error("response has both ok and overflow");
`endif

endmodule
